FILE: sv/all_nearest_smaller_values_core_assert.svh
// Assertion macros for the all-nearest-smaller-values core.
`ifndef ALL_NEAREST_SMALLER_VALUES_CORE_ASSERT_SVH
`define ALL_NEAREST_SMALLER_VALUES_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ANSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ansv: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ANSV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ansv: next-cycle check failed");

`else

`define ANSV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ANSV_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/ansv_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package ansv_pkg;

    // Fixed field widths
    localparam int POS_W       = 10;
    localparam int SAMPLE_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int VALUE_W_MAX = 64;

    // Parameter defaults
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_WIDTH_DEF  = 32;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] RES_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] RES_OVERFLOW  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic query;
        logic init_fwd;
        logic init_bwd;
        logic fetch;
        logic pop;
        logic pop_fill;
        logic push;
        logic step;
        logic set_ready;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic pop_needed;
        logic pass_end;
        logic bwd;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/ansv_datapath.sv
// Datapath: value store, index stack, neighbor stores and result registers.
`default_nettype none

`include "all_nearest_smaller_values_core_assert.svh"

module ansv_datapath #(
    parameter int MAX_ELEMENTS = ansv_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = ansv_pkg::VALUE_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire ansv_pkg::t_cmd              i_cmd,
    output ansv_pkg::t_sts                   o_sts,
    input  wire signed [ansv_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire [ansv_pkg::POS_W-1:0]        i_query_position,
    output logic                             o_strobe,
    output logic [ansv_pkg::POS_W-1:0]       o_echo_position,
    output logic [ansv_pkg::POS_W-1:0]       o_left_index,
    output logic                             o_left_found,
    output logic [ansv_pkg::POS_W-1:0]       o_right_index,
    output logic                             o_right_found,
    output logic [ansv_pkg::STATUS_W-1:0]    o_status
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W = (CNT_W > ansv_pkg::POS_W) ? CNT_W : ansv_pkg::POS_W;
    localparam int STK_W = IDX_W + VALUE_WIDTH;
    localparam int RES_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMENTS);

    // Memories
    logic [VALUE_WIDTH-1:0] r_value_mem [MAX_ELEMENTS];
    logic [STK_W-1:0]       r_stack_mem [MAX_ELEMENTS];
    logic [RES_W-1:0]       r_left_mem  [MAX_ELEMENTS];
    logic [RES_W-1:0]       r_right_mem [MAX_ELEMENTS];

    // Control registers
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_ready, n_ready;
    logic [IDX_W-1:0]              r_i, n_i;
    logic [CNT_W-1:0]              r_top, n_top;
    logic                          r_bwd, n_bwd;
    logic                          r_strobe, n_strobe;
    logic [ansv_pkg::STATUS_W-1:0] r_status, n_status;

    // Payload registers
    logic [IDX_W-1:0]           r_top_idx;
    logic [VALUE_WIDTH-1:0]     r_top_val;
    logic [VALUE_WIDTH-1:0]     r_val_rd;
    logic [STK_W-1:0]           r_stk_rd;
    logic [RES_W-1:0]           r_left_rd;
    logic [RES_W-1:0]           r_right_rd;
    logic [ansv_pkg::POS_W-1:0] r_q_pos;

    logic [ansv_pkg::VALUE_W_MAX-1:0] w_ext;
    logic [VALUE_WIDTH-1:0]           w_val;
    logic [CNT_W-1:0]                 w_count_eff;
    logic                             w_full;
    logic [CNT_W-1:0]                 w_cnt_m1;
    logic [CNT_W-1:0]                 w_top_m2;
    logic                             w_q_bad;
    logic [IDX_W-1:0]                 w_q_addr;
    logic [RES_W-1:0]                 w_res_entry;
    logic                             w_ok;

    // Sample sign-extended or truncated to the stored width, two's complement
    assign w_ext = {{(ansv_pkg::VALUE_W_MAX - ansv_pkg::SAMPLE_W)
                     {i_sample_value[ansv_pkg::SAMPLE_W-1]}}, i_sample_value};
    assign w_val = w_ext[VALUE_WIDTH-1:0];

    // A load after a finished computation starts a new array
    assign w_count_eff = r_ready ? '0 : r_count;
    assign w_full      = (w_count_eff == MAX_COUNT);
    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_top_m2    = r_top - CNT_W'(2);

    assign w_q_bad  = !r_ready || (CMP_W'(i_query_position) >= CMP_W'(r_count));
    assign w_q_addr = IDX_W'(i_query_position);

    // Neighbor entry: found bit over the cached top index
    assign w_res_entry = (r_top != '0) ? {1'b1, r_top_idx} : '0;

    // Status to the controller
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.pop_needed = (r_top != '0) && ($signed(r_top_val) >= $signed(r_val_rd));
    assign o_sts.pass_end   = r_bwd ? (r_i == '0) : (r_i == w_cnt_m1[IDX_W-1:0]);
    assign o_sts.bwd        = r_bwd;

    // Next state of control registers
    always_comb begin
        n_count  = r_count;
        n_ready  = r_ready;
        n_i      = r_i;
        n_top    = r_top;
        n_bwd    = r_bwd;
        n_strobe = 1'b0;
        n_status = r_status;
        if (i_cmd.load) begin
            n_ready = 1'b0;
            if (w_full) begin
                n_count  = w_count_eff;
                n_strobe = 1'b1;
                n_status = ansv_pkg::RES_OVERFLOW;
            end else begin
                n_count = w_count_eff + CNT_W'(1);
            end
        end
        if (i_cmd.query) begin
            n_strobe = 1'b1;
            n_status = w_q_bad ? ansv_pkg::RES_NOT_READY : ansv_pkg::RES_OK;
        end
        if (i_cmd.push) begin
            n_top = r_top + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_top = r_top - CNT_W'(1);
        end
        if (i_cmd.step) begin
            n_i = r_bwd ? (r_i - IDX_W'(1)) : (r_i + IDX_W'(1));
        end
        if (i_cmd.init_fwd) begin
            n_i   = '0;
            n_top = '0;
            n_bwd = 1'b0;
        end
        if (i_cmd.init_bwd) begin
            n_i   = w_cnt_m1[IDX_W-1:0];
            n_top = '0;
            n_bwd = 1'b1;
        end
        if (i_cmd.set_ready) begin
            n_ready = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ready  <= 1'b0;
            r_i      <= '0;
            r_top    <= '0;
            r_bwd    <= 1'b0;
            r_strobe <= 1'b0;
            r_status <= ansv_pkg::RES_OK;
        end else begin
            r_count  <= n_count;
            r_ready  <= n_ready;
            r_i      <= n_i;
            r_top    <= n_top;
            r_bwd    <= n_bwd;
            r_strobe <= n_strobe;
            r_status <= n_status;
        end
    end

    // Value store: append on load, read the current element on fetch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_value_mem[w_count_eff[IDX_W-1:0]] <= w_val;
        end
        if (i_cmd.fetch) begin
            r_val_rd <= r_value_mem[r_i];
        end
    end

    // Index stack: entries carry index and value; top entry cached in registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack_mem[r_top[IDX_W-1:0]] <= {r_i, r_val_rd};
        end
        if (i_cmd.pop && (r_top >= CNT_W'(2))) begin
            r_stk_rd <= r_stack_mem[w_top_m2[IDX_W-1:0]];
        end
    end

    // Top-of-stack cache
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top_idx <= r_i;
            r_top_val <= r_val_rd;
        end else if (i_cmd.pop_fill) begin
            {r_top_idx, r_top_val} <= r_stk_rd;
        end
    end

    // Neighbor stores: written by the passes, read by queries
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !r_bwd) begin
            r_left_mem[r_i] <= w_res_entry;
        end
        if (i_cmd.push && r_bwd) begin
            r_right_mem[r_i] <= w_res_entry;
        end
        if (i_cmd.query) begin
            r_left_rd  <= r_left_mem[w_q_addr];
            r_right_rd <= r_right_mem[w_q_addr];
            r_q_pos    <= i_query_position;
        end
    end

    // Result beat
    assign w_ok            = (r_status == ansv_pkg::RES_OK);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_echo_position = (r_status == ansv_pkg::RES_OVERFLOW) ? '0 : r_q_pos;
    assign o_left_found    = w_ok && r_left_rd[IDX_W];
    assign o_left_index    = o_left_found ? ansv_pkg::POS_W'(r_left_rd[IDX_W-1:0]) : '0;
    assign o_right_found   = w_ok && r_right_rd[IDX_W];
    assign o_right_index   = o_right_found ? ansv_pkg::POS_W'(r_right_rd[IDX_W-1:0]) : '0;

    // Stack never holds more entries than the array has elements
    `ANSV_ASSERT_IMP(a_push_bound, i_clk, i_rst_n, i_cmd.push, r_top < r_count)
    // Pop only from a non-empty stack
    `ANSV_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_top != '0)
    // Element count saturates at capacity
    `ANSV_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_COUNT)

endmodule

`default_nettype wire

FILE: sv/ansv_ctrl.sv
// Controller: item decode and the sequencer for the two stack passes.
`default_nettype none

`include "all_nearest_smaller_values_core_assert.svh"

module ansv_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire                 i_action,
    input  wire                 i_last_value,
    input  wire ansv_pkg::t_sts i_sts,
    output ansv_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_POPW  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       w_accept;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ansv_pkg::ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_last_value) begin
                            n_state = ST_START;
                        end
                    end else begin
                        o_cmd.query = 1'b1;
                    end
                end
            end
            ST_START: begin
                if (i_sts.count_zero) begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.init_fwd = 1'b1;
                    n_state        = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.pop_needed) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_POPW;
                end else begin
                    o_cmd.push = 1'b1;
                    if (!i_sts.pass_end) begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_FETCH;
                    end else if (i_sts.bwd) begin
                        o_cmd.set_ready = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        o_cmd.init_bwd = 1'b1;
                        n_state        = ST_FETCH;
                    end
                end
            end
            ST_POPW: begin
                o_cmd.pop_fill = 1'b1;
                n_state        = ST_CMP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A last load always launches the passes
    `ANSV_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, o_cmd.load && i_last_value, r_state == ST_START)
    // The end of the backward pass frees the block
    `ANSV_ASSERT_NXT(a_bwd_done, i_clk, i_rst_n, o_cmd.push && i_sts.pass_end && i_sts.bwd, !busy)

endmodule

`default_nettype wire

FILE: sv/all_nearest_smaller_values_core.sv
// Top level of the all-nearest-smaller-values core.
`default_nettype none

// All nearest smaller values. A load beat (action 0) appends one signed value;
// busy stays low. The load marked last starts a forward and a backward stack
// pass over the stored array, and busy stays high until both are done; each
// pass fetches every element from the value store and reads the index stack
// when a pop leaves entries on it. A query beat (action 1) leaves busy low. A
// result beat is shown on the o_ result ports for exactly one cycle, with
// o_strobe high, in the cycle after the item that causes it; the receiver
// cannot stall it, so capture it then. An overflowing load returns status 2,
// a query before computation or beyond the count status 1.
module all_nearest_smaller_values_core #(
    parameter int MAX_ELEMENTS = ansv_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = ansv_pkg::VALUE_WIDTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_action,
    input  wire signed [ansv_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire                                 i_last_value,
    input  wire [ansv_pkg::POS_W-1:0]           i_query_position,
    output logic                                o_strobe,
    output logic [ansv_pkg::POS_W-1:0]          o_echo_position,
    output logic [ansv_pkg::POS_W-1:0]          o_left_index,
    output logic                                o_left_found,
    output logic [ansv_pkg::POS_W-1:0]          o_right_index,
    output logic                                o_right_found,
    output logic [ansv_pkg::STATUS_W-1:0]       o_status
);

    ansv_pkg::t_cmd w_cmd;
    ansv_pkg::t_sts w_sts;

    // Sequencer
    ansv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_last_value (i_last_value),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    // Stores, stack and result registers
    ansv_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample_value   (i_sample_value),
        .i_query_position (i_query_position),
        .o_strobe         (o_strobe),
        .o_echo_position  (o_echo_position),
        .o_left_index     (o_left_index),
        .o_left_found     (o_left_found),
        .o_right_index    (o_right_index),
        .o_right_found    (o_right_found),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire
